// ----- src/lrt_pkg.sv -----
// Package for the logistic regression trainer: payload types, codes, constants and tables.
package lrt_pkg;

  localparam int MAX_FEATURES = 16;
  localparam int IDX_W = $clog2(MAX_FEATURES);
  localparam int SIG_ENTRIES = 256;
  localparam int SIG_W = $clog2(SIG_ENTRIES);
  localparam int LOSS_ENTRIES = 1024;
  localparam int LOSS_W = $clog2(LOSS_ENTRIES);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_TRAIN = 2'd1;
  localparam logic [1:0] MODE_VAL = 2'd2;
  localparam logic [1:0] MODE_READ = 2'd3;

  localparam logic [31:0] STEP_SCALE_RESET = 32'd429496730;
  localparam logic [4:0] FEATURE_COUNT_RESET = 5'd16;
  localparam logic REG_STEP_SCALE = 1'b0;
  localparam logic REG_FEATURE_COUNT = 1'b1;

  localparam longint Q30 = 64'sd1 << 30;
  localparam longint LN2_Q30 = 64'sd744261118;
  localparam longint LOSS_FLOOR = 64'sd2263533;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] feature_index;
    logic signed [15:0] feature_value;
    logic signed [31:0] weight_in;
    logic label;
    logic last_feature;
    logic last_sample;
  } item_t;

  typedef struct packed {
    logic signed [31:0] weight_out;
    logic [37:0] train_loss_sum;
    logic [37:0] val_loss_sum;
    logic improved;
    logic pass_done;
  } result_t;

  typedef enum logic [1:0] {OP_LOAD, OP_SAMPLE, OP_READ} op_t;

  typedef struct packed {
    op_t op;
    logic training;
    logic in_use;
    logic [IDX_W-1:0] idx;
    logic signed [15:0] x;
    logic signed [31:0] w;
    logic label;
    logic last_feature;
    logic last_sample;
  } job_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_SIG, ST_LOSS, ST_GMUL, ST_GADD, ST_CLOSE,
    ST_UPA, ST_UPB, ST_UPR, ST_UPW, ST_COPY, ST_OUT
  } state_t;

  typedef logic [16:0] sig_rom_t [SIG_ENTRIES];
  typedef logic [21:0] loss_rom_t [LOSS_ENTRIES + 1];

  // Quotient of two non-negative values by shift and subtract.
  function automatic longint div_pos(longint a, longint b);
    longint qv;
    longint rv;
    qv = 0;
    rv = 0;
    for (int i = 62; i >= 0; i--) begin
      rv = (rv << 1) | ((a >>> i) & 64'sd1);
      qv = qv << 1;
      if (rv >= b) begin
        rv = rv - b;
        qv = qv | 64'sd1;
      end
    end
    return qv;
  endfunction

  function automatic longint exp_neg_frac(longint f);
    longint s;
    longint t;
    s = Q30;
    t = Q30;
    for (int n = 1; n <= 20; n++) begin
      t = div_pos((t * f) >>> 30, longint'(n));
      if ((n & 1) == 1) begin
        s = s - t;
      end else begin
        s = s + t;
      end
    end
    return s;
  endfunction

  function automatic longint exp_neg(longint t);
    longint e1;
    longint r;
    longint n;
    e1 = exp_neg_frac(Q30);
    r = exp_neg_frac(t & (Q30 - 1));
    n = t >>> 30;
    for (int c = 0; c < 9; c++) begin
      if (c < n) begin
        r = (r * e1 + (Q30 >>> 1)) >>> 30;
      end
    end
    return r;
  endfunction

  function automatic longint ln_ratio(longint num, longint dn);
    longint k;
    longint m;
    longint s;
    longint s2;
    longint p;
    longint sum;
    k = 0;
    while ((dn << (k + 1)) <= num) begin
      k = k + 1;
    end
    m = div_pos(num << 30, dn << k);
    s = div_pos((m - Q30) << 30, m + Q30);
    s2 = (s * s) >>> 30;
    sum = s;
    p = s;
    for (int n = 1; n <= 14; n++) begin
      p = (p * s2) >>> 30;
      sum = sum + div_pos(p, longint'(2 * n + 1));
    end
    return k * LN2_Q30 + 2 * sum;
  endfunction

  function automatic sig_rom_t build_sig();
    sig_rom_t r;
    longint zi;
    longint t;
    longint dn;
    longint pp;
    for (int i = 0; i < SIG_ENTRIES; i++) begin
      zi = (((2 * longint'(i) + 1) * (64'sd8 << 30)) >>> SIG_W) - (64'sd8 << 30);
      t = (zi < 0) ? -zi : zi;
      dn = Q30 + exp_neg(t);
      pp = div_pos((64'sd1 << 46) + (dn >>> 1), dn);
      r[i] = (zi >= 0) ? 17'(pp) : 17'(64'sd65536 - pp);
    end
    return r;
  endfunction

  function automatic loss_rom_t build_loss();
    loss_rom_t r;
    r[0] = 22'(LOSS_FLOOR);
    for (int i = 1; i <= LOSS_ENTRIES; i++) begin
      r[i] = 22'((ln_ratio(LOSS_ENTRIES, longint'(i)) + (64'sd1 << 13)) >>> 14);
    end
    return r;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig();
  localparam loss_rom_t LOSS_ROM = build_loss();

endpackage

// ----- src/lrt_front.sv -----
// Front end: accepts items, classifies them and queues them for the back end.
module lrt_front (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_ready,
  input  lrt_pkg::item_t item,
  input  logic [4:0] feature_count,
  output logic job_valid,
  output lrt_pkg::job_t job,
  input  logic job_pop
);

  lrt_pkg::job_t slots [lrt_pkg::QUEUE_DEPTH];
  lrt_pkg::job_t jn;
  logic [lrt_pkg::QPTR_W-1:0] wptr;
  logic [lrt_pkg::QPTR_W-1:0] rptr;
  logic [lrt_pkg::QCNT_W-1:0] count;
  logic push;
  logic pop;

  assign item_ready = (count != lrt_pkg::QCNT_W'(lrt_pkg::QUEUE_DEPTH));
  assign push = item_valid && item_ready;
  assign job_valid = (count != '0);
  assign pop = job_pop && job_valid;
  assign job = slots[rptr];

  always_comb begin
    jn.training = (item.mode == lrt_pkg::MODE_TRAIN);
    jn.in_use = ({1'b0, item.feature_index} < feature_count);
    jn.idx = lrt_pkg::IDX_W'(item.feature_index);
    jn.x = item.feature_value;
    jn.w = item.weight_in;
    jn.label = item.label;
    jn.last_feature = item.last_feature;
    jn.last_sample = item.last_sample;
    case (item.mode)
      lrt_pkg::MODE_LOAD: jn.op = lrt_pkg::OP_LOAD;
      lrt_pkg::MODE_READ: jn.op = lrt_pkg::OP_READ;
      default: jn.op = lrt_pkg::OP_SAMPLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= jn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == lrt_pkg::QPTR_W'(lrt_pkg::QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == lrt_pkg::QPTR_W'(lrt_pkg::QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- src/lrt_back.sv -----
// Back end: sequencer that carries out queued items and holds the result register.
module lrt_back (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  input  lrt_pkg::job_t job,
  output logic job_pop,
  input  logic [31:0] step_scale,
  output logic result_valid,
  input  logic result_ready,
  output lrt_pkg::result_t result
);

  localparam logic [lrt_pkg::IDX_W-1:0] LAST_J = lrt_pkg::IDX_W'(lrt_pkg::MAX_FEATURES - 1);

  lrt_pkg::state_t state;
  lrt_pkg::state_t state_next;
  lrt_pkg::job_t jb;
  lrt_pkg::result_t res;

  logic signed [31:0] cur_w [lrt_pkg::MAX_FEATURES];
  logic signed [31:0] best_w [lrt_pkg::MAX_FEATURES];
  logic signed [47:0] grad [lrt_pkg::MAX_FEATURES];
  logic signed [15:0] sbuf [lrt_pkg::MAX_FEATURES];
  logic [lrt_pkg::MAX_FEATURES-1:0] present;
  logic signed [47:0] dot;
  logic [37:0] tacc;
  logic [37:0] vacc;
  logic [37:0] best_loss;
  logic [lrt_pkg::IDX_W-1:0] j;
  logic [lrt_pkg::IDX_W-1:0] j_next;

  logic signed [47:0] prod;
  logic [16:0] p;
  logic [21:0] loss;
  logic signed [17:0] err;
  logic signed [33:0] gprod;
  logic [63:0] ua;
  logic [47:0] ub;
  logic [44:0] ur;

  logic signed [47:0] zc;
  logic [39:0] off;
  logic [16:0] q;
  logic [37:0] tnew;
  logic [37:0] vnew;
  logic [47:0] mag;
  logic [48:0] lowsum;
  logic signed [46:0] nw;
  logic signed [31:0] nw_sat;

  function automatic logic signed [47:0] sat48(logic signed [47:0] a, logic signed [47:0] b);
    logic signed [48:0] s;
    s = {a[47], a} + {b[47], b};
    if (s[48] != s[47]) begin
      return s[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    end
    return s[47:0];
  endfunction

  function automatic logic [37:0] loss_add(logic [37:0] a, logic [21:0] b);
    logic [38:0] s;
    s = {1'b0, a} + 39'(b);
    return s[38] ? '1 : s[37:0];
  endfunction

  always_comb begin
    if (dot > 48'sh007F_FFFF_FFFF) begin
      zc = 48'sh007F_FFFF_FFFF;
    end else if (dot < -48'sh0080_0000_0000) begin
      zc = -48'sh0080_0000_0000;
    end else begin
      zc = dot;
    end
    off = {~zc[39], zc[38:0]};
    q = jb.label ? p : 17'd65536 - p;
    tnew = loss_add(tacc, loss);
    vnew = loss_add(vacc, loss);
    mag = grad[j][47] ? 48'(-grad[j]) : grad[j];
    lowsum = {13'd0, ua[19:0], 16'd0} + {1'b0, ub} + (49'd1 << 35);
    nw = 47'(cur_w[j]) - (grad[j][47] ? -$signed({2'b00, ur}) : $signed({2'b00, ur}));
    if (nw > 47'sh0000_7FFF_FFFF) begin
      nw_sat = 32'sh7FFF_FFFF;
    end else if (nw < -47'sh0000_8000_0000) begin
      nw_sat = -32'sh8000_0000;
    end else begin
      nw_sat = nw[31:0];
    end
    j_next = (j == LAST_J) ? '0 : j + 1'b1;
  end

  always_comb begin
    state_next = state;
    job_pop = 1'b0;
    case (state)
      lrt_pkg::ST_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          case (job.op)
            lrt_pkg::OP_SAMPLE: begin
              if (job.in_use) begin
                state_next = lrt_pkg::ST_MUL;
              end else if (job.last_feature) begin
                state_next = lrt_pkg::ST_SIG;
              end else begin
                state_next = lrt_pkg::ST_OUT;
              end
            end
            default: state_next = lrt_pkg::ST_OUT;
          endcase
        end
      end
      lrt_pkg::ST_MUL: state_next = lrt_pkg::ST_ACC;
      lrt_pkg::ST_ACC: state_next = jb.last_feature ? lrt_pkg::ST_SIG : lrt_pkg::ST_OUT;
      lrt_pkg::ST_SIG: state_next = lrt_pkg::ST_LOSS;
      lrt_pkg::ST_LOSS: state_next = jb.training ? lrt_pkg::ST_GMUL : lrt_pkg::ST_CLOSE;
      lrt_pkg::ST_GMUL: state_next = lrt_pkg::ST_GADD;
      lrt_pkg::ST_GADD: state_next = (j == LAST_J) ? lrt_pkg::ST_CLOSE : lrt_pkg::ST_GMUL;
      lrt_pkg::ST_CLOSE: begin
        if (!jb.last_sample) begin
          state_next = lrt_pkg::ST_OUT;
        end else if (jb.training) begin
          state_next = lrt_pkg::ST_UPA;
        end else if (vnew < best_loss) begin
          state_next = lrt_pkg::ST_COPY;
        end else begin
          state_next = lrt_pkg::ST_OUT;
        end
      end
      lrt_pkg::ST_UPA: state_next = lrt_pkg::ST_UPB;
      lrt_pkg::ST_UPB: state_next = lrt_pkg::ST_UPR;
      lrt_pkg::ST_UPR: state_next = lrt_pkg::ST_UPW;
      lrt_pkg::ST_UPW: state_next = (j == LAST_J) ? lrt_pkg::ST_OUT : lrt_pkg::ST_UPA;
      lrt_pkg::ST_COPY: state_next = (j == LAST_J) ? lrt_pkg::ST_OUT : lrt_pkg::ST_COPY;
      lrt_pkg::ST_OUT: begin
        if (!result_valid || result_ready) begin
          state_next = lrt_pkg::ST_IDLE;
        end
      end
      default: state_next = lrt_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lrt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      dot <= '0;
      present <= '0;
      tacc <= '0;
      vacc <= '0;
      best_loss <= '1;
      j <= '0;
      for (int i = 0; i < lrt_pkg::MAX_FEATURES; i++) begin
        cur_w[i] <= '0;
        best_w[i] <= '0;
        grad[i] <= '0;
      end
    end else begin
      if ((state == lrt_pkg::ST_OUT) && (!result_valid || result_ready)) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      case (state)
        lrt_pkg::ST_IDLE: begin
          j <= '0;
          if (job_valid) begin
            case (job.op)
              lrt_pkg::OP_LOAD: begin
                cur_w[job.idx] <= job.w;
                best_w[job.idx] <= job.w;
              end
              lrt_pkg::OP_SAMPLE: begin
                if (job.in_use) begin
                  present[job.idx] <= 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
        lrt_pkg::ST_ACC: dot <= sat48(dot, prod);
        lrt_pkg::ST_GADD: begin
          if (present[j]) begin
            grad[j] <= sat48(grad[j], 48'(gprod));
          end
          j <= j_next;
        end
        lrt_pkg::ST_CLOSE: begin
          dot <= '0;
          present <= '0;
          j <= '0;
          if (jb.training) begin
            tacc <= jb.last_sample ? '0 : tnew;
          end else begin
            vacc <= jb.last_sample ? '0 : vnew;
            if (jb.last_sample && (vnew < best_loss)) begin
              best_loss <= vnew;
            end
          end
        end
        lrt_pkg::ST_UPW: begin
          cur_w[j] <= nw_sat;
          grad[j] <= '0;
          j <= j_next;
        end
        lrt_pkg::ST_COPY: begin
          best_w[j] <= cur_w[j];
          j <= j_next;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      lrt_pkg::ST_IDLE: begin
        if (job_valid) begin
          jb <= job;
          res.weight_out <= (job.op == lrt_pkg::OP_READ) ? best_w[job.idx] : '0;
          res.train_loss_sum <= '0;
          res.val_loss_sum <= '0;
          res.improved <= 1'b0;
          res.pass_done <= 1'b0;
          if (job.op == lrt_pkg::OP_SAMPLE && job.in_use) begin
            sbuf[job.idx] <= job.x;
          end
        end
      end
      lrt_pkg::ST_MUL: prod <= jb.x * cur_w[jb.idx];
      lrt_pkg::ST_SIG: p <= lrt_pkg::SIG_ROM[off[39 -: lrt_pkg::SIG_W]];
      lrt_pkg::ST_LOSS: begin
        loss <= lrt_pkg::LOSS_ROM[q[16:16-lrt_pkg::LOSS_W]];
        err <= $signed({1'b0, p}) - (jb.label ? 18'sd65536 : 18'sd0);
      end
      lrt_pkg::ST_GMUL: gprod <= err * sbuf[j];
      lrt_pkg::ST_CLOSE: begin
        if (jb.last_sample) begin
          res.pass_done <= 1'b1;
          if (jb.training) begin
            res.train_loss_sum <= tnew;
          end else begin
            res.val_loss_sum <= vnew;
            res.improved <= (vnew < best_loss);
          end
        end
      end
      lrt_pkg::ST_UPA: ua <= mag[47:16] * step_scale;
      lrt_pkg::ST_UPB: ub <= mag[15:0] * step_scale;
      lrt_pkg::ST_UPR: ur <= 45'(ua[63:20]) + 45'(lowsum[48:36]);
      lrt_pkg::ST_OUT: begin
        if (!result_valid || result_ready) begin
          result <= res;
        end
      end
      default: ;
    endcase
  end

  a_close_clears: assert property (@(posedge clk) disable iff (rst)
    state == lrt_pkg::ST_CLOSE |=> (dot == '0 && present == '0))
    else $error("Sample close did not clear the dot product and present bits.");

  a_best_falls: assert property (@(posedge clk) disable iff (rst)
    !rst |=> best_loss <= $past(best_loss))
    else $error("Best validation loss rose.");

  a_improved_done: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.improved |-> result.pass_done && result.train_loss_sum == '0)
    else $error("Improved flag without a closing validation pass.");

endmodule

// ----- src/logistic_regression_trainer_unit.sv -----
// Top level of the logistic regression trainer: configuration registers and the two halves.
//
// Items arrive on item_valid/item_ready/item, one feature element each, and every item
// yields exactly one result on result_valid/result_ready/result, in order. Mode 0 loads a
// weight, mode 3 reads a best weight, modes 1 and 2 carry training and validation elements.
// A two-entry queue separates the front end, which accepts and classifies items, from the
// back end sequencer, so items are taken while a result waits to be collected.
// An item is picked up once the back end is idle. Load and read items go straight to
// output; an element in use passes multiply and accumulate states. A sample end adds
// sigmoid, loss and close states, and in training a gradient multiply and add for each
// of the 16 stored features. A training pass end adds a weight update per feature in two
// partial products, a round and a write; an improving validation end copies 16 weights.
// The configuration port is APB style: step_scale at address 0, feature_count at address 4.
// Configuration must be written only while the block is idle; this is not enforced.
// Reset clears the weights, gradient sums, loss totals and queue, and sets the best loss to
// all ones; the block takes items in the cycle after reset is released.
// When the receiver stalls, the result is held and the back end waits with the next one.
module logistic_regression_trainer_unit (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_ready,
  input  lrt_pkg::item_t item,
  output logic result_valid,
  input  logic result_ready,
  output lrt_pkg::result_t result,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  logic [31:0] step_scale;
  logic [4:0] feature_count;
  logic job_valid;
  logic job_pop;
  lrt_pkg::job_t job;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == lrt_pkg::REG_FEATURE_COUNT) ? {27'd0, feature_count} : step_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_scale <= lrt_pkg::STEP_SCALE_RESET;
      feature_count <= lrt_pkg::FEATURE_COUNT_RESET;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == lrt_pkg::REG_STEP_SCALE) begin
        step_scale <= pwdata;
      end else begin
        feature_count <= pwdata[4:0];
      end
    end
  end

  lrt_front u_front (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .feature_count(feature_count),
    .job_valid(job_valid),
    .job(job),
    .job_pop(job_pop)
  );

  lrt_back u_back (
    .clk(clk),
    .rst(rst),
    .job_valid(job_valid),
    .job(job),
    .job_pop(job_pop),
    .step_scale(step_scale),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

endmodule

// ----- tb/logistic_regression_trainer_unit_tb.sv -----
// Trainer testbench: random training and validation passes, loads, reads checked against a predictor.
module logistic_regression_trainer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] ADDR_STEP_SCALE = 3'd0;
  localparam logic [2:0] ADDR_FEATURE_COUNT = 3'd4;
  localparam int STALL_LIMIT = 20000;
  localparam longint Z_LIMIT = 64'sd8 <<< 36;
  localparam longint SAT_HI = (64'sd1 <<< 47) - 1;
  localparam longint SAT_LO = -(64'sd1 <<< 47);
  localparam longint unsigned LOSS_TOP = (64'd1 << 38) - 1;
  localparam longint ONE_Q30 = 64'sd1 <<< 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  lrt_pkg::item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  lrt_pkg::result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logistic_regression_trainer_unit dut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_ready(item_ready), .item(item),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  lrt_pkg::item_t pending_items[$];
  lrt_pkg::result_t expected_results[$];
  int send_idle_pct = 27;
  int recv_idle_pct = 47;
  bit hold_items = 1'b0;
  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int passes_closed = 0;
  int stall_cycles = 0;

  int unsigned sig_tab [lrt_pkg::SIG_ENTRIES];
  int unsigned loss_tab [lrt_pkg::LOSS_ENTRIES + 1];
  longint unsigned m_step;
  int m_count;
  longint m_weights [lrt_pkg::MAX_FEATURES];
  longint m_best [lrt_pkg::MAX_FEATURES];
  longint m_grad [lrt_pkg::MAX_FEATURES];
  longint m_feat [lrt_pkg::MAX_FEATURES];
  bit m_seen [lrt_pkg::MAX_FEATURES];
  longint m_dot;
  longint unsigned m_train_sum;
  longint unsigned m_val_sum;
  longint unsigned m_best_loss;

  function automatic void queue_item(lrt_pkg::item_t it);
    pending_items.insert(pending_items.size(), it);
  endfunction

  function automatic longint exp_frac_q30(longint f);
    longint s;
    longint t;
    s = ONE_Q30;
    t = ONE_Q30;
    for (int n = 1; n <= 20; n++) begin
      t = ((t * f) >>> 30) / n;
      s = (n % 2 == 1) ? s - t : s + t;
    end
    return s;
  endfunction

  function automatic longint exp_q30(longint t);
    longint e1;
    longint r;
    e1 = exp_frac_q30(ONE_Q30);
    r = exp_frac_q30(t & (ONE_Q30 - 1));
    for (longint n = t >>> 30; n > 0; n--) begin
      r = (r * e1 + (ONE_Q30 >>> 1)) >>> 30;
    end
    return r;
  endfunction

  function automatic longint log_ratio_q30(longint num, longint dn);
    longint k;
    longint m;
    longint s;
    longint s2;
    longint p;
    longint acc;
    k = 0;
    while ((dn << (k + 1)) <= num) begin
      k++;
    end
    m = (num << 30) / (dn << k);
    s = ((m - ONE_Q30) << 30) / (m + ONE_Q30);
    s2 = (s * s) >>> 30;
    acc = s;
    p = s;
    for (int n = 1; n <= 14; n++) begin
      p = (p * s2) >>> 30;
      acc = acc + p / (2 * n + 1);
    end
    return k * 64'sd744261118 + 2 * acc;
  endfunction

  function automatic void build_curves();
    longint zi;
    longint t;
    longint dn;
    longint pp;
    for (int i = 0; i < lrt_pkg::SIG_ENTRIES; i++) begin
      zi = ((2 * longint'(i) + 1) * (64'sd8 <<< 30)) / lrt_pkg::SIG_ENTRIES - (64'sd8 <<< 30);
      t = (zi < 0) ? -zi : zi;
      dn = ONE_Q30 + exp_q30(t);
      pp = ((64'sd1 <<< 46) + dn / 2) / dn;
      sig_tab[i] = (zi >= 0) ? int'(pp) : int'(64'sd65536 - pp);
    end
    loss_tab[0] = 2263533;
    for (int i = 1; i <= lrt_pkg::LOSS_ENTRIES; i++) begin
      loss_tab[i] = int'((log_ratio_q30(lrt_pkg::LOSS_ENTRIES, i) + 64'sd8192) >>> 14);
    end
  endfunction

  function automatic longint sat48(longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  function automatic longint unsigned add_loss(longint unsigned a, longint unsigned b);
    return (a + b > LOSS_TOP) ? LOSS_TOP : a + b;
  endfunction

  function automatic longint weight_step(longint g, longint unsigned sc);
    longint unsigned mag;
    longint unsigned a;
    longint unsigned b;
    longint unsigned r;
    mag = (g < 0) ? -g : g;
    a = (mag >> 16) * sc;
    b = (mag & 64'hFFFF) * sc;
    r = (a >> 20) + ((((a & 64'hFFFFF) << 16) + b + (64'd1 << 35)) >> 36);
    return (g < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic void clear_model();
    m_step = 64'(lrt_pkg::STEP_SCALE_RESET);
    m_count = int'(lrt_pkg::FEATURE_COUNT_RESET);
    for (int j = 0; j < lrt_pkg::MAX_FEATURES; j++) begin
      m_weights[j] = 0;
      m_best[j] = 0;
      m_grad[j] = 0;
      m_feat[j] = 0;
      m_seen[j] = 1'b0;
    end
    m_dot = 0;
    m_train_sum = 0;
    m_val_sum = 0;
    m_best_loss = LOSS_TOP;
  endfunction

  function automatic lrt_pkg::result_t train_step(lrt_pkg::item_t it);
    lrt_pkg::result_t r;
    longint x;
    longint z;
    longint err;
    longint nw;
    longint unsigned p;
    longint unsigned q;
    longint unsigned loss;
    bit training;
    r = '0;
    x = longint'(it.feature_value);
    if (it.mode == lrt_pkg::MODE_LOAD) begin
      m_weights[it.feature_index] = longint'(it.weight_in);
      m_best[it.feature_index] = longint'(it.weight_in);
    end else if (it.mode == lrt_pkg::MODE_READ) begin
      r.weight_out = 32'(m_best[it.feature_index]);
    end else begin
      training = (it.mode == lrt_pkg::MODE_TRAIN);
      if (it.feature_index < m_count) begin
        m_feat[it.feature_index] = x;
        m_seen[it.feature_index] = 1'b1;
        m_dot = sat48(m_dot + x * m_weights[it.feature_index]);
      end
      if (it.last_feature) begin
        z = m_dot;
        if (z > Z_LIMIT - 1) z = Z_LIMIT - 1;
        if (z < -Z_LIMIT) z = -Z_LIMIT;
        p = sig_tab[longint'(z + Z_LIMIT) >>> 32];
        if (training) begin
          err = longint'(p) - (it.label ? 65536 : 0);
          for (int j = 0; j < lrt_pkg::MAX_FEATURES; j++) begin
            if (m_seen[j]) m_grad[j] = sat48(m_grad[j] + err * m_feat[j]);
          end
        end
        q = it.label ? p : 65536 - p;
        loss = loss_tab[q >> 6];
        m_dot = 0;
        for (int j = 0; j < lrt_pkg::MAX_FEATURES; j++) m_seen[j] = 1'b0;
        if (training) begin
          m_train_sum = add_loss(m_train_sum, loss);
          if (it.last_sample) begin
            for (int j = 0; j < lrt_pkg::MAX_FEATURES; j++) begin
              nw = m_weights[j] - weight_step(m_grad[j], m_step);
              if (nw > 64'sd2147483647) nw = 64'sd2147483647;
              if (nw < -64'sd2147483648) nw = -64'sd2147483648;
              m_weights[j] = nw;
              m_grad[j] = 0;
            end
            r.train_loss_sum = m_train_sum[37:0];
            m_train_sum = 0;
            r.pass_done = 1'b1;
          end
        end else begin
          m_val_sum = add_loss(m_val_sum, loss);
          if (it.last_sample) begin
            r.val_loss_sum = m_val_sum[37:0];
            if (m_val_sum < m_best_loss) begin
              m_best_loss = m_val_sum;
              m_best = m_weights;
              r.improved = 1'b1;
            end
            m_val_sum = 0;
            r.pass_done = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        expected_results.insert(expected_results.size(), train_step(item));
        items_sent++;
      end
      if (!item_valid || item_ready) begin
        if (pending_items.size() > 0 && !hold_items &&
            $urandom_range(99) >= send_idle_pct) begin
          item <= pending_items.pop_front();
          item_valid <= 1'b1;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    lrt_pkg::result_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected result %p", result);
        end else begin
          want = expected_results.pop_front();
          if (result.pass_done) passes_closed++;
          if (result.weight_out !== want.weight_out ||
              result.train_loss_sum !== want.train_loss_sum ||
              result.val_loss_sum !== want.val_loss_sum ||
              result.improved !== want.improved || result.pass_done !== want.pass_done) begin
            mismatches++;
            if (mismatches <= 10) $display("Mismatch: expected %p, got %p", want, result);
          end
        end
      end
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic reg_write(logic [2:0] addr, logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_STEP_SCALE) m_step = 64'(value);
    else m_count = int'(value[4:0]);
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !item_valid && expected_results.size() == 0);
    repeat (150) @(posedge clk);
  endtask

  function automatic lrt_pkg::item_t make_item(logic [1:0] mode, int idx,
                                               logic signed [15:0] x, logic signed [31:0] w,
                                               bit lab, bit lf, bit ls);
    lrt_pkg::item_t it;
    it.mode = mode;
    it.feature_index = idx[3:0];
    it.feature_value = x;
    it.weight_in = w;
    it.label = lab;
    it.last_feature = lf;
    it.last_sample = ls;
    return it;
  endfunction

  function automatic logic [15:0] rand_feature();
    return 16'($signed(16'($urandom)) >>> $urandom_range(0, 12));
  endfunction

  task automatic queue_pass(logic [1:0] mode, int samples);
    int idxs[$];
    for (int s = 0; s < samples; s++) begin
      idxs.delete();
      for (int f = 0; f < lrt_pkg::MAX_FEATURES; f++) begin
        if ((f < m_count || $urandom_range(9) == 0) && $urandom_range(9) != 0) begin
          idxs.insert(idxs.size(), f);
        end
        if ($urandom_range(19) == 0) idxs.insert(idxs.size(), f);
      end
      if (idxs.size() == 0) idxs.insert(0, 0);
      foreach (idxs[k]) begin
        queue_item(make_item(mode, idxs[k], rand_feature(), $urandom,
            1'($urandom_range(1)), k == idxs.size() - 1,
            (k == idxs.size() - 1) ? (s == samples - 1) : 1'($urandom_range(1))));
      end
    end
  endtask

  task automatic queue_round();
    for (int j = 0; j < lrt_pkg::MAX_FEATURES; j++) begin
      if ($urandom_range(3) == 0) begin
        queue_item(make_item(lrt_pkg::MODE_LOAD, j, 16'($urandom),
            32'($signed($urandom) >>> $urandom_range(0, 10)),
            1'($urandom), 1'($urandom), 1'($urandom)));
      end
    end
    queue_pass(lrt_pkg::MODE_TRAIN, $urandom_range(1, 4));
    queue_pass(lrt_pkg::MODE_TRAIN, $urandom_range(1, 3));
    queue_pass(lrt_pkg::MODE_VAL, $urandom_range(1, 3));
    for (int j = 0; j < 4; j++) queue_item(lrt_pkg::item_t'(57'({$urandom, $urandom})));
    for (int j = 0; j < 4; j++) begin
      queue_item(make_item(lrt_pkg::MODE_READ, int'($urandom_range(15)), 16'($urandom),
          $urandom, 1'($urandom), 1'($urandom), 1'($urandom)));
    end
  endtask

  initial begin
    logic [31:0] scales[6];
    int counts[6];
    int target;
    build_curves();
    clear_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    queue_item(make_item(lrt_pkg::MODE_LOAD, 0, 0, 32'sh7FFFFFFF, 0, 0, 0));
    queue_item(make_item(lrt_pkg::MODE_LOAD, 1, 0, 32'sh80000000, 0, 0, 0));
    queue_item(make_item(lrt_pkg::MODE_LOAD, 15, 0, 32'sh01000000, 0, 0, 0));
    queue_item(make_item(lrt_pkg::MODE_READ, 0, 0, 0, 0, 0, 0));
    queue_item(make_item(lrt_pkg::MODE_READ, 1, 0, 0, 0, 0, 0));
    queue_item(make_item(lrt_pkg::MODE_READ, 15, 0, 0, 0, 0, 0));
    queue_item(make_item(lrt_pkg::MODE_TRAIN, 0, 16'sh7FFF, 0, 0, 0, 0));
    queue_item(make_item(lrt_pkg::MODE_TRAIN, 15, 16'sh8000, 0, 1, 1, 0));
    queue_item(make_item(lrt_pkg::MODE_TRAIN, 1, 16'sh7FFF, 0, 0, 0, 1));
    queue_item(make_item(lrt_pkg::MODE_TRAIN, 2, 16'sh1000, 0, 0, 0, 0));
    queue_item(make_item(lrt_pkg::MODE_TRAIN, 2, 16'sh1000, 0, 0, 1, 0));
    queue_item(make_item(lrt_pkg::MODE_TRAIN, 3, 16'sh0000, 0, 1, 1, 1));
    queue_item(make_item(lrt_pkg::MODE_VAL, 0, 16'sh0800, 0, 1, 0, 0));
    queue_item(make_item(lrt_pkg::MODE_TRAIN, 1, 16'shF000, 0, 0, 0, 0));
    queue_item(make_item(lrt_pkg::MODE_VAL, 2, 16'sh0100, 0, 0, 1, 1));
    queue_item(make_item(lrt_pkg::MODE_VAL, 0, 16'sh7FFF, 0, 0, 1, 1));
    queue_item(make_item(lrt_pkg::MODE_READ, 0, 0, 0, 0, 0, 0));
    queue_item(make_item(lrt_pkg::MODE_READ, 1, 0, 0, 0, 0, 0));
    drain();

    scales = '{32'hFFFFFFFF, 32'h0, $urandom, lrt_pkg::STEP_SCALE_RESET, $urandom,
               32'hFFFFFFFF};
    counts = '{16, 1, 16, $urandom_range(1, 16), $urandom_range(1, 16), 5};
    for (int ph = 0; ph < 6; ph++) begin
      send_idle_pct = (ph < 2) ? 27 : (ph < 4) ? 47 : 0;
      recv_idle_pct = (ph < 2) ? 47 : (ph < 4) ? 27 : 0;
      reg_write(ADDR_STEP_SCALE, scales[ph]);
      reg_write(ADDR_FEATURE_COUNT, 32'(counts[ph]));
      target = items_sent + 50;
      hold_items = 1'b0;
      while (items_sent + pending_items.size() < target) begin
        queue_round();
        if (ph == 2) begin
          wait (pending_items.size() == 0 && !item_valid);
          hold_items = 1'b1;
          wait (expected_results.size() == 0);
          hold_items = 1'b0;
        end
      end
      drain();
    end

    $display("Covered %0d items and %0d results over six register settings,", items_sent,
             results_seen);
    $display("with %0d training and validation passes closed.", passes_closed);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- logistic_regression_trainer_unit.f -----
src/lrt_pkg.sv
src/lrt_front.sv
src/lrt_back.sv
src/logistic_regression_trainer_unit.sv
tb/logistic_regression_trainer_unit_tb.sv
